>>> design/mdfb_pkg.sv
package mdfb_pkg;

    // configuration register indexes
    localparam int CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PAN_ID       = 3'd0,
        CFG_SHORT_ADDR   = 3'd1,
        CFG_LONG_ADDR    = 3'd2,
        CFG_ACK_REQUEST  = 3'd3,
        CFG_LONG_SOURCE  = 3'd4,
        CFG_INCL_SRC_PAN = 3'd5
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic [15:0] pan_id;
        logic [15:0] short_addr;
        logic [63:0] long_addr;
        logic        ack_request;
        logic        long_source;
        logic        incl_src_pan;
    } t_cfg;

    // destination address modes
    typedef enum logic [1:0] {
        DST_SHORT       = 2'd0,
        DST_LONG        = 2'd1,
        DST_BROADCAST   = 2'd2,
        DST_UNSUPPORTED = 2'd3
    } t_dst_mode;

    // emission phase of the item in flight
    typedef enum logic [4:0] {
        PH_HDR  = 5'b00001,
        PH_PAY  = 5'b00010,
        PH_FCS0 = 5'b00100,
        PH_FCS1 = 5'b01000,
        PH_ERR  = 5'b10000
    } t_phase;

    // header position counter, longest header is 23 bytes
    localparam int PosW = 5;

    // frame control and fcs constants
    localparam logic [7:0]  FC0_BASE      = 8'h01;
    localparam logic [7:0]  FC0_ACK       = 8'h20;
    localparam logic [7:0]  FC0_PAN_COMP  = 8'h40;
    localparam logic [7:0]  FC1_BASE      = 8'h88;
    localparam logic [7:0]  FC1_LONG_DST  = 8'h04;
    localparam logic [7:0]  FC1_LONG_SRC  = 8'h40;
    localparam logic [15:0] FCS_POLY      = 16'h8408;
    localparam logic [15:0] BCAST_ADDR    = 16'hFFFF;

    // reflected crc-16 over one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ FCS_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> design/mac_data_frame_builder_top.sv
// Builds 802.15.4 data frames from a byte stream: the first payload byte of a frame
// is preceded by the MAC header (9 to 23 bytes), payload bytes pass through, and the
// byte marked tlast is followed by the two FCS bytes, low byte first. The output runs
// one byte per cycle, unless held by tready, from a single output register, which sets
// the rate: a middle payload byte gives one output byte, a frame's first byte gives the
// header and then the byte, a last byte adds the two FCS bytes, and an unsupported
// destination gives one error byte (tuser set, tlast set). Remaining bytes of an errored
// frame are taken one per cycle with no output. A new input request is taken in the same
// cycle that the previous item puts out its final byte. Configuration writes are always
// ready and are meant to be done while no frame byte is pending.
module mac_data_frame_builder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // payload_byte[7:0], dest_addr[71:8]
    input  logic [1:0]  i_s_axis_tuser,   // dst_mode[1:0]
    input  logic        i_s_axis_tlast,   // payload_last
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // out_byte[7:0]
    output logic        o_m_axis_tuser,   // frame_error
    output logic        o_m_axis_tlast    // out_last
);
    import mdfb_pkg::*;

    t_cfg w_cfg;

    // frame tracking at the input side
    logic r_in_frame;
    logic r_dropping;
    logic [7:0] r_seq;

    // item in flight
    logic            r_item_valid;
    t_phase          r_phase;
    logic [PosW-1:0] r_pos;
    logic [7:0]      r_it_byte;
    logic            r_it_last;
    t_dst_mode       r_it_mode;
    logic [63:0]     r_it_addr;
    logic [7:0]      r_it_seq;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_err;

    logic            w_emit;
    logic            w_accept;
    logic            w_done;
    logic [7:0]      w_byte;
    logic            w_last;
    logic            w_err;
    logic            w_crc_upd;
    logic            w_crc_clear;
    t_phase          n_phase;
    logic [PosW-1:0] n_pos;
    logic [7:0]      w_hdr_byte;
    logic [PosW-1:0] w_hdr_len;
    logic [15:0]     w_crc;
    t_dst_mode       w_in_mode;

    assign o_cfg_ready = 1'b1;

    mdfb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    mdfb_hdr_sel u_hdr (
        .i_cfg       (w_cfg),
        .i_pos       (r_pos),
        .i_mode      (r_it_mode),
        .i_dest_addr (r_it_addr),
        .i_seq       (r_it_seq),
        .o_byte      (w_hdr_byte),
        .o_len       (w_hdr_len)
    );

    mdfb_fcs u_fcs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_crc_clear),
        .i_upd   (w_crc_upd),
        .i_byte  (w_byte),
        .o_crc   (w_crc)
    );

    // one byte leaves per cycle when the output register is free
    assign w_emit      = r_item_valid && (!r_out_valid || i_m_axis_tready);
    assign w_crc_clear = (r_phase == PH_HDR) && (r_pos == '0);

    // byte selection and phase stepping
    always_comb begin
        w_byte    = '0;
        w_last    = 1'b0;
        w_err     = 1'b0;
        w_crc_upd = 1'b0;
        w_done    = 1'b0;
        n_phase   = r_phase;
        n_pos     = r_pos;
        unique case (r_phase)
            PH_HDR: begin
                w_byte    = w_hdr_byte;
                w_crc_upd = w_emit;
                if (r_pos == w_hdr_len - PosW'(1)) begin
                    n_phase = PH_PAY;
                end else begin
                    n_pos = r_pos + PosW'(1);
                end
            end
            PH_PAY: begin
                w_byte    = r_it_byte;
                w_crc_upd = w_emit;
                if (r_it_last) begin
                    n_phase = PH_FCS0;
                end else begin
                    w_done = 1'b1;
                end
            end
            PH_FCS0: begin
                w_byte  = w_crc[7:0];
                n_phase = PH_FCS1;
            end
            PH_FCS1: begin
                w_byte = w_crc[15:8];
                w_last = 1'b1;
                w_done = 1'b1;
            end
            PH_ERR: begin
                w_last = 1'b1;
                w_err  = 1'b1;
                w_done = 1'b1;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
    end

    assign o_s_axis_tready = !r_item_valid || (w_emit && w_done);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_mode       = t_dst_mode'(i_s_axis_tuser);

    // control state: frame tracking, item slot and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_dropping   <= 1'b0;
            r_seq        <= '0;
            r_item_valid <= 1'b0;
            r_phase      <= PH_PAY;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // step through the item in flight
            if (w_emit && !w_done) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
            end
            // item slot refilled by a new request as the old one finishes
            if (w_accept && !r_dropping) begin
                r_item_valid <= 1'b1;
            end else if (w_emit && w_done) begin
                r_item_valid <= 1'b0;
            end
            if (w_accept) begin
                if (r_dropping) begin
                    if (i_s_axis_tlast) begin
                        r_dropping <= 1'b0;
                        r_in_frame <= 1'b0;
                    end
                end else begin
                    r_pos <= '0;
                    if (!r_in_frame) begin
                        if (w_in_mode == DST_UNSUPPORTED) begin
                            r_phase <= PH_ERR;
                            if (!i_s_axis_tlast) begin
                                r_dropping <= 1'b1;
                                r_in_frame <= 1'b1;
                            end
                        end else begin
                            r_phase    <= PH_HDR;
                            r_seq      <= r_seq + 8'd1;
                            r_in_frame <= !i_s_axis_tlast;
                        end
                    end else begin
                        r_phase    <= PH_PAY;
                        r_in_frame <= !i_s_axis_tlast;
                    end
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept && !r_dropping) begin
            r_it_byte <= i_s_axis_tdata[7:0];
            r_it_last <= i_s_axis_tlast;
            r_it_mode <= w_in_mode;
            r_it_addr <= i_s_axis_tdata[71:8];
            r_it_seq  <= r_seq;
        end
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
            r_out_err  <= w_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_err;

    // checks
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_last)
        else $error("error byte without last");

    a_hdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_valid && (r_phase == PH_HDR) |-> (r_pos < w_hdr_len))
        else $error("header position past header length");

    a_drop_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> r_in_frame)
        else $error("dropping outside a frame");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_item_valid)
        else $error("input stalled with no item in flight");

endmodule

>>> design/mdfb_cfg_regs.sv
module mdfb_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [mdfb_pkg::CfgIdxW-1:0] i_idx,
    input  logic [63:0]                  i_data,
    output mdfb_pkg::t_cfg               o_cfg
);
    import mdfb_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{pan_id: 16'h0000, short_addr: 16'h0000, long_addr: 64'h0,
                       ack_request: 1'b0, long_source: 1'b0, incl_src_pan: 1'b1};
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_idx))
                CFG_PAN_ID:       r_cfg.pan_id       <= i_data[15:0];
                CFG_SHORT_ADDR:   r_cfg.short_addr   <= i_data[15:0];
                CFG_LONG_ADDR:    r_cfg.long_addr    <= i_data;
                CFG_ACK_REQUEST:  r_cfg.ack_request  <= i_data[0];
                CFG_LONG_SOURCE:  r_cfg.long_source  <= i_data[0];
                CFG_INCL_SRC_PAN: r_cfg.incl_src_pan <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/mdfb_hdr_sel.sv
module mdfb_hdr_sel (
    input  mdfb_pkg::t_cfg            i_cfg,
    input  logic [mdfb_pkg::PosW-1:0] i_pos,
    input  mdfb_pkg::t_dst_mode       i_mode,
    input  logic [63:0]               i_dest_addr,
    input  logic [7:0]                i_seq,
    output logic [7:0]                o_byte,
    output logic [mdfb_pkg::PosW-1:0] o_len
);
    import mdfb_pkg::*;

    logic [7:0]      w_fc0;
    logic [7:0]      w_fc1;
    logic [63:0]     w_dst;
    logic [PosW-1:0] w_dlen;
    logic [PosW-1:0] w_span_len;
    logic [PosW-1:0] w_slen;
    logic [PosW-1:0] w_span_start;
    logic [PosW-1:0] w_src_start;
    logic [PosW-1:0] w_dst_off;
    logic [PosW-1:0] w_span_off;
    logic [PosW-1:0] w_src_off;
    logic [63:0]     w_src;

    // field values and layout of the header
    always_comb begin
        w_fc0 = FC0_BASE;
        if (i_cfg.ack_request) w_fc0 = w_fc0 | FC0_ACK;
        if (!i_cfg.incl_src_pan) w_fc0 = w_fc0 | FC0_PAN_COMP;
        w_fc1 = FC1_BASE;
        if (i_mode == DST_LONG) w_fc1 = w_fc1 | FC1_LONG_DST;
        if (i_cfg.long_source) w_fc1 = w_fc1 | FC1_LONG_SRC;

        unique case (i_mode)
            DST_LONG:      w_dst = i_dest_addr;
            DST_BROADCAST: w_dst = {48'd0, BCAST_ADDR};
            default:       w_dst = {48'd0, i_dest_addr[15:0]};
        endcase
        w_src = i_cfg.long_source ? i_cfg.long_addr : {48'd0, i_cfg.short_addr};

        w_dlen       = (i_mode == DST_LONG) ? PosW'(8) : PosW'(2);
        w_span_len   = i_cfg.incl_src_pan ? PosW'(2) : PosW'(0);
        w_slen       = i_cfg.long_source ? PosW'(8) : PosW'(2);
        w_span_start = PosW'(5) + w_dlen;
        w_src_start  = w_span_start + w_span_len;
        o_len        = w_src_start + w_slen;

        w_dst_off  = i_pos - PosW'(5);
        w_span_off = i_pos - w_span_start;
        w_src_off  = i_pos - w_src_start;
    end

    // byte at the current header position
    always_comb begin
        priority if (i_pos == PosW'(0)) begin
            o_byte = w_fc0;
        end else if (i_pos == PosW'(1)) begin
            o_byte = w_fc1;
        end else if (i_pos == PosW'(2)) begin
            o_byte = i_seq;
        end else if (i_pos == PosW'(3)) begin
            o_byte = i_cfg.pan_id[7:0];
        end else if (i_pos == PosW'(4)) begin
            o_byte = i_cfg.pan_id[15:8];
        end else if (i_pos < w_span_start) begin
            o_byte = w_dst[w_dst_off[2:0]*8 +: 8];
        end else if (i_pos < w_src_start) begin
            o_byte = w_span_off[0] ? i_cfg.pan_id[15:8] : i_cfg.pan_id[7:0];
        end else begin
            o_byte = w_src[w_src_off[2:0]*8 +: 8];
        end
    end

endmodule

>>> design/mdfb_fcs.sv
module mdfb_fcs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_upd,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import mdfb_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // first header byte starts from zero
    assign n_crc = crc_byte(i_clear ? 16'h0000 : r_crc, i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
        end else if (i_upd) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule
